[hw/rtl/assert_macros.svh]
// Assertion macros shared by the animation frame sequencer RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AFS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define AFS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define AFS_ASSERT(lbl, clk, rst, prop)
`define AFS_NEVER(lbl, clk, rst, cond)
`endif
`endif

[hw/rtl/afs_pkg.sv]
// Types and constants of the animation frame sequencer.
// No dependencies; used by afs_div and animation_frame_sequencer.
package afs_pkg;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FRAMES_W   = 9;
  localparam int SLOT_W     = 8;
  localparam int DELAY_W    = 16;
  localparam int ELAPSED_W  = 40;
  localparam int ACC_W      = 48;
  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 2'd3;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [FRAMES_W-1:0] FALLBACK_RST = 9'd0;
  localparam logic [DELAY_W-1:0]  FALLBACK_DEF = 16'd100;
  localparam logic [SPEED_W-1:0]  SPEED_ONE    = 16'd256;

  typedef struct packed {
    logic                 req_type;
    logic [SLOT_W-1:0]    frame_slot;
    logic [DELAY_W-1:0]   frame_delay_ms;
    logic [ELAPSED_W-1:0] elapsed_q16;
    logic [SLOT_W-1:0]    seed_frame;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] frame_index;
    logic              presentation_changed;
    logic              rejected;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
    logic [ACC_W-1:0] rem;
  } div_rsp_t;

endpackage

[hw/rtl/afs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module afs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/afs_div.sv]
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on afs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afs_div (
  input  logic              clk,
  input  logic              rst,
  input  afs_pkg::div_req_t req,
  output afs_pkg::div_rsp_t rsp
);

  localparam int W     = afs_pkg::ACC_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic             done;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CNT_W'(W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

  `AFS_NEVER(a_start_while_busy, clk, rst, req.start && busy)
  `AFS_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy))
  `AFS_NEVER(a_busy_count_zero, clk, rst, busy && cnt == '0)

endmodule

[hw/rtl/animation_frame_sequencer.sv]
// Animation frame sequencer: delay table, effective delay pass and frame walk.
// Depends on afs_pkg, afs_ram, afs_div and assert_macros.svh.
//
// Usage. A request is taken when start is high and busy is low. A write request
// stores frame_delay_ms at frame_slot; it and a refused advance answer in the
// next cycle with done high for one cycle, and busy stays low.
// An accepted advance raises busy. The block first sweeps the delay table once,
// dividing each frame's delay by the speed in a shared 48-step divider and
// keeping the effective delays in a second RAM. When the accumulated time is
// at least the cycle length, one modulo on the same divider follows; then a
// walk over the stored effective delays checks each frame in turn. done then
// pulses for one cycle with the result and busy falls in the same cycle.
// The receiver cannot stall: done flags each result for one cycle only, and
// res holds it until the next result.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle;
// the user must keep to that, as the block itself does not enforce it.
// Reset returns the registers to their defaults and clears the accumulator and
// frame state; the delay table is not cleared and must be written before use.
`include "assert_macros.svh"
module animation_frame_sequencer #(
  parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF,
  parameter int FRAC_BITS  = afs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  afs_pkg::req_t                   req,
  output logic                            done,
  output afs_pkg::res_t                   res,
  input  logic                            cfg_we,
  input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW   = $clog2(MAX_FRAMES);
  localparam int FW   = afs_pkg::FRAMES_W;
  localparam int SW   = afs_pkg::SLOT_W;
  localparam int AW   = afs_pkg::ACC_W;
  localparam int DW   = afs_pkg::DELAY_W + FRAC_BITS + 8;
  localparam int CW   = DW + FW;
  localparam int CMPW = (CW > AW) ? CW : AW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_DIVGO = 9'b000000100,
    ST_DIVW  = 9'b000001000,
    ST_MOD   = 9'b000010000,
    ST_MODW  = 9'b000100000,
    ST_WRD   = 9'b001000000,
    ST_WCHK  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t st;

  logic [FW-1:0]                  frames_in_use;
  logic [afs_pkg::DELAY_W-1:0]    fallback_delay_ms;
  logic [afs_pkg::SPEED_W-1:0]    speed_q8;
  logic [afs_pkg::DELAY_W-1:0]    min_interval_ms;

  logic [AW-1:0] elapsed_acc;
  logic [SW-1:0] logical_index;
  logic [SW-1:0] last_presented;
  logic          initialized;

  logic [FW-1:0] n_lat;
  logic [FW-1:0] cnt;
  logic [SW-1:0] idx;
  logic [CW-1:0] cycle;
  logic          phase;

  logic                          accept;
  logic                          rej;
  logic [AW:0]                   acc_sum;
  logic [SW-1:0]                 seed_ok;
  logic [SW+IW-1:0]              slot_wide;
  logic [FW+IW-1:0]              cnt_wide;
  logic [SW+IW-1:0]              idx_wide;
  logic                          tab_we;
  logic [afs_pkg::DELAY_W-1:0]   tab_rdata;
  logic [afs_pkg::DELAY_W-1:0]   base;
  logic [afs_pkg::SPEED_W-1:0]   spd;
  logic [DW-1:0]                 d_raw;
  logic [DW-1:0]                 d_min;
  logic [DW-1:0]                 d_eff;
  logic                          eff_we;
  logic [DW-1:0]                 eff_rdata;
  logic [CMPW-1:0]               cycle_ext;
  logic                          wrap;
  logic [FW-1:0]                 idx_inc;
  logic [SW-1:0]                 idx_next;
  logic [SW-1:0]                 pres;
  afs_pkg::div_req_t             div_req;
  afs_pkg::div_rsp_t             div_rsp;

  assign busy   = (st != ST_IDLE);
  assign accept = start && !busy;
  assign rej    = (req.elapsed_q16 == '0) || (frames_in_use < FW'(2))
               || (32'(frames_in_use) > 32'(MAX_FRAMES));
  assign acc_sum = {1'b0, elapsed_acc} + (AW + 1)'(req.elapsed_q16);
  assign seed_ok = ({1'b0, req.seed_frame} < frames_in_use) ? req.seed_frame : '0;

  assign slot_wide = {{IW{1'b0}}, req.frame_slot};
  assign cnt_wide  = {{IW{1'b0}}, cnt};
  assign idx_wide  = {{IW{1'b0}}, idx};
  assign tab_we    = accept && (req.req_type == afs_pkg::REQ_WRITE)
                  && (32'(slot_wide) < 32'(MAX_FRAMES));

  afs_ram #(.WIDTH(afs_pkg::DELAY_W), .DEPTH(MAX_FRAMES)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (slot_wide[IW-1:0]),
    .wdata (req.frame_delay_ms),
    .raddr (cnt_wide[IW-1:0]),
    .rdata (tab_rdata)
  );

  // Zero table entries fall back to the register, and a zero fallback to 1 ms.
  always_comb begin
    base = tab_rdata;
    if (base == '0) begin
      base = fallback_delay_ms;
    end
    if (base == '0) begin
      base = afs_pkg::DELAY_W'(1);
    end
  end
  assign spd = (speed_q8 == '0) ? afs_pkg::SPEED_ONE : speed_q8;

  assign cycle_ext = CMPW'(cycle);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = AW'(base) << (FRAC_BITS + 8);
    div_req.divisor  = AW'(spd);
    if (st == ST_MOD) begin
      div_req.dividend = elapsed_acc;
      div_req.divisor  = cycle_ext[AW-1:0];
      div_req.start    = CMPW'(elapsed_acc) >= cycle_ext;
    end else if (st == ST_DIVGO) begin
      div_req.start = 1'b1;
    end
  end

  afs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    d_raw = div_rsp.quo[DW-1:0];
    d_min = DW'(min_interval_ms) << FRAC_BITS;
    d_eff = d_raw;
    if ((min_interval_ms != '0) && (d_eff < d_min)) begin
      d_eff = d_min;
    end
    if (d_eff == '0) begin
      d_eff = DW'(1);
    end
  end
  assign eff_we = (st == ST_DIVW) && div_rsp.done;

  afs_ram #(.WIDTH(DW), .DEPTH(MAX_FRAMES)) u_eff (
    .clk   (clk),
    .we    (eff_we),
    .waddr (cnt_wide[IW-1:0]),
    .wdata (d_eff),
    .raddr (idx_wide[IW-1:0]),
    .rdata (eff_rdata)
  );

  assign idx_inc  = {1'b0, idx} + FW'(1);
  assign wrap     = (idx_inc == n_lat);
  assign idx_next = wrap ? '0 : idx_inc[SW-1:0];
  assign pres     = (phase && (idx == last_presented)) ? idx_next : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      st                <= ST_IDLE;
      done              <= 1'b0;
      frames_in_use     <= afs_pkg::FALLBACK_RST;
      fallback_delay_ms <= afs_pkg::FALLBACK_DEF;
      speed_q8          <= afs_pkg::SPEED_ONE;
      min_interval_ms   <= '0;
      elapsed_acc       <= '0;
      logical_index     <= '0;
      last_presented    <= '0;
      initialized       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == afs_pkg::REQ_WRITE) begin
              done                     <= 1'b1;
              res.frame_index          <= last_presented;
              res.presentation_changed <= 1'b0;
              res.rejected             <= 1'b0;
            end else if (rej) begin
              done                     <= 1'b1;
              res.frame_index          <= req.seed_frame;
              res.presentation_changed <= 1'b0;
              res.rejected             <= 1'b1;
            end else begin
              if (!initialized) begin
                logical_index  <= seed_ok;
                last_presented <= seed_ok;
                idx            <= seed_ok;
                initialized    <= 1'b1;
              end else begin
                idx <= ({1'b0, logical_index} < frames_in_use) ? logical_index : '0;
              end
              elapsed_acc <= acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
              n_lat <= frames_in_use;
              cnt   <= '0;
              cycle <= '0;
              phase <= 1'b0;
              st    <= ST_RD;
            end
          end
        end
        ST_RD: begin
          st <= ST_DIVGO;
        end
        ST_DIVGO: begin
          st <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            cycle <= cycle + CW'(d_eff);
            if (cnt + FW'(1) == n_lat) begin
              st <= ST_MOD;
            end else begin
              cnt <= cnt + FW'(1);
              st  <= ST_RD;
            end
          end
        end
        ST_MOD: begin
          cnt <= '0;
          if (div_req.start) begin
            phase <= 1'b1;
            st    <= ST_MODW;
          end else begin
            st <= ST_WRD;
          end
        end
        ST_MODW: begin
          if (div_rsp.done) begin
            elapsed_acc <= div_rsp.rem;
            st          <= ST_WRD;
          end
        end
        ST_WRD: begin
          st <= (cnt == n_lat) ? ST_FIN : ST_WCHK;
        end
        ST_WCHK: begin
          if (elapsed_acc < AW'(eff_rdata)) begin
            st <= ST_FIN;
          end else begin
            elapsed_acc <= elapsed_acc - AW'(eff_rdata);
            idx         <= idx_next;
            phase       <= 1'b1;
            cnt         <= cnt + FW'(1);
            st          <= ST_WRD;
          end
        end
        ST_FIN: begin
          logical_index            <= idx;
          last_presented           <= pres;
          done                     <= 1'b1;
          res.frame_index          <= pres;
          res.presentation_changed <= (pres != last_presented);
          res.rejected             <= 1'b0;
          st                       <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          afs_pkg::CFG_FRAMES: begin
            frames_in_use <= cfg_data[FW-1:0];
            initialized   <= 1'b0;
          end
          afs_pkg::CFG_FALLBACK: fallback_delay_ms <= cfg_data;
          afs_pkg::CFG_SPEED:    speed_q8          <= cfg_data;
          afs_pkg::CFG_MIN:      min_interval_ms   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  `AFS_ASSERT(a_done_source, clk, rst, done |-> $past((st == ST_FIN) || (start && !busy)))
  `AFS_NEVER(a_reject_changed, clk, rst, done && res.rejected && res.presentation_changed)
  `AFS_ASSERT(a_walk_index, clk, rst, (st == ST_WCHK) |-> ({1'b0, idx} < n_lat))

endmodule
